// File: design/variable_size_block_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// Allocator assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_SIZE_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define VARIABLE_SIZE_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTH
`define VSBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define VSBA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VSBA_ASSERT(label, prop, msg)
`define VSBA_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: design/vsba_pkg.sv
// ----------------------------------------------------------------------------
// Allocator package
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package vsba_pkg;

  localparam int ADDR_BITS       = 16;
  localparam int MAX_EXTENTS_DEF = 32;
  localparam int POOL_RESET      = 65535;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;
  localparam logic [1:0] POL_SPARE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic REG_POOL_SIZE  = 1'b0;
  localparam logic REG_FIT_POLICY = 1'b1;

  localparam int ENTRY_W = 2 * ADDR_BITS + 1;

  typedef logic [ADDR_BITS-1:0] unit_t;

  typedef struct packed {
    logic clear_wr;
    logic load;
    logic quick_done;
    logic scan_init;
    logic rd;
    logic eval;
    logic post;
    logic second;
    logic finish;
  } vsba_cmd_t;

  typedef struct packed {
    logic quick;
    logic two_wr;
    logic out_busy;
    logic pool_wr;
  } vsba_sts_t;

  function automatic unit_t sat_add(unit_t a, unit_t b);
    logic [ADDR_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ADDR_BITS] ? {ADDR_BITS{1'b1}} : s[ADDR_BITS-1:0];
  endfunction

endpackage

// File: design/vsba_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module vsba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/vsba_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences table clear, request check, table scan and update.
// ----------------------------------------------------------------------------
`include "variable_size_block_allocator_core_defines.svh"

module vsba_ctrl #(
  parameter int MAX_EXTENTS = vsba_pkg::MAX_EXTENTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  vsba_pkg::vsba_sts_t            sts,
  output vsba_pkg::vsba_cmd_t            cmd,
  output logic [$clog2(MAX_EXTENTS)-1:0] idx
);
  import vsba_pkg::*;

  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam logic [CW-1:0] LAST = CW'(MAX_EXTENTS - 1);
  localparam logic [CW-1:0] ENDC = CW'(MAX_EXTENTS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_UPD1  = 3'd4;
  localparam logic [2:0] S_UPD2  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]    state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          in_acc;

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign idx      = cnt[IW-1:0];

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          cmd.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cnt_next = '0;
        if (sts.quick) begin
          cmd.quick_done = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.scan_init = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd   = (cnt != ENDC);
        cmd.eval = (cnt != '0);
        cnt_next = cnt + 1'b1;
        if (cnt == ENDC) begin
          state_next = S_UPD1;
        end
      end
      S_UPD1: begin
        cmd.post = 1'b1;
        state_next = sts.two_wr ? S_UPD2 : S_OUT;
      end
      S_UPD2: begin
        cmd.second = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (sts.pool_wr) begin
      state_next = S_CLEAR;
      cnt_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  `VSBA_ASSERT(a_accept_to_check, in_acc && !sts.pool_wr |=> state == S_CHECK, "accept lost")
  `VSBA_ASSERT(a_scan_bound, state == S_SCAN |-> cnt <= ENDC, "scan counter overrun")
  `VSBA_ASSERT(a_finish_free, cmd.finish |-> !sts.out_busy, "result overwrote pending beat")
  `VSBA_ASSERT(a_second_after_post, state == S_UPD2 |-> $past(state) == S_UPD1, "bad merge write")

endmodule

// File: design/vsba_dp.sv
// ----------------------------------------------------------------------------
// Allocator datapath
// Extent table RAM, request registers, scan trackers and result register.
// ----------------------------------------------------------------------------
module vsba_dp #(
  parameter int MAX_EXTENTS = vsba_pkg::MAX_EXTENTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic                           cfg_index,
  input  logic [15:0]                    cfg_data,
  input  logic                           in_kind,
  input  vsba_pkg::unit_t                in_offset,
  input  vsba_pkg::unit_t                in_size,
  input  vsba_pkg::vsba_cmd_t            cmd,
  input  logic [$clog2(MAX_EXTENTS)-1:0] idx,
  output vsba_pkg::vsba_sts_t            sts,
  input  logic                           m_tready,
  output logic                           m_tvalid,
  output vsba_pkg::unit_t                res_offset,
  output logic [1:0]                     res_status
);
  import vsba_pkg::*;

  localparam int IW = $clog2(MAX_EXTENTS);

  unit_t       pool_size, free_total;
  logic [1:0]  fit_policy, pol;
  logic        kind;
  unit_t       off, size;

  logic        we, re;
  logic [IW-1:0] waddr, rd_idx;
  logic [ENTRY_W-1:0] wdata, rdata;
  logic        e_v;
  unit_t       e_s, e_l;

  logic        pick_f, prev_f, next_f, slot_f;
  logic [IW-1:0] pick_i, prev_i, next_i, slot_i;
  unit_t       pick_s, pick_l, prev_s, prev_l, next_s, next_l;

  logic        better, cand, alloc_ok, pa, na;
  unit_t       new_l;
  logic [1:0]  post_status;
  unit_t       r_off;
  logic [1:0]  r_status;

  assign pol = (fit_policy == POL_SPARE) ? POL_FIRST : fit_policy;
  assign {e_v, e_s, e_l} = rdata;

  assign sts.pool_wr  = cfg_wen && (cfg_index == REG_POOL_SIZE);
  assign sts.quick    = (kind == KIND_FREE) ? (size == '0)
                                            : (size == '0 || size > free_total);
  assign sts.two_wr   = (kind == KIND_FREE) && pa && na;
  assign sts.out_busy = m_tvalid && !m_tready;

  vsba_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_EXTENTS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (idx),
    .rdata (rdata)
  );

  assign re = cmd.rd;

  always_comb begin
    cand = e_v && (pol == POL_WORST || e_l >= size);
    if (!pick_f) begin
      better = 1'b1;
    end else if (pol == POL_BEST && e_l != pick_l) begin
      better = e_l < pick_l;
    end else if (pol == POL_WORST && e_l != pick_l) begin
      better = e_l > pick_l;
    end else begin
      better = e_s < pick_s;
    end
  end

  assign alloc_ok = pick_f && (pick_l >= size);
  assign new_l    = pick_l - size;
  assign pa = prev_f && (({1'b0, prev_s} + {1'b0, prev_l}) == {1'b0, off});
  assign na = next_f && (({1'b0, off} + {1'b0, size}) == {1'b0, next_s});

  always_comb begin
    we          = 1'b0;
    waddr       = idx;
    wdata       = '0;
    post_status = ST_OK;
    if (cmd.clear_wr) begin
      we    = 1'b1;
      wdata = (idx == '0) ? {pool_size != '0, unit_t'(0), pool_size} : '0;
    end else if (cmd.second) begin
      we    = 1'b1;
      waddr = next_i;
    end else if (cmd.post) begin
      if (kind == KIND_ALLOC) begin
        waddr = pick_i;
        if (alloc_ok) begin
          we    = 1'b1;
          wdata = (new_l == '0) ? '0 : {1'b1, unit_t'(pick_s + size), new_l};
        end else begin
          post_status = ST_NOFIT;
        end
      end else if (pa) begin
        we    = 1'b1;
        waddr = prev_i;
        wdata = {1'b1, prev_s, sat_add(prev_l, na ? sat_add(size, next_l) : size)};
      end else if (na) begin
        we    = 1'b1;
        waddr = next_i;
        wdata = {1'b1, off, sat_add(next_l, size)};
      end else if (slot_f) begin
        we    = 1'b1;
        waddr = slot_i;
        wdata = {1'b1, off, size};
      end else begin
        post_status = ST_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size  <= unit_t'(POOL_RESET);
      free_total <= unit_t'(POOL_RESET);
      fit_policy <= POL_FIRST;
    end else if (cfg_wen) begin
      if (cfg_index == REG_POOL_SIZE) begin
        pool_size  <= cfg_data;
        free_total <= cfg_data;
      end else begin
        fit_policy <= cfg_data[1:0];
      end
    end else if (cmd.post && post_status == ST_OK) begin
      free_total <= (kind == KIND_ALLOC) ? free_total - size : sat_add(free_total, size);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= in_kind;
      off  <= in_offset;
      size <= in_size;
    end
    if (cmd.rd) begin
      rd_idx <= idx;
    end
    if (cmd.scan_init) begin
      pick_f <= 1'b0;
      prev_f <= 1'b0;
      next_f <= 1'b0;
      slot_f <= 1'b0;
    end else if (cmd.eval) begin
      if (kind == KIND_ALLOC) begin
        if (cand && better) begin
          pick_f <= 1'b1;
          pick_i <= rd_idx;
          pick_s <= e_s;
          pick_l <= e_l;
        end
      end else if (!e_v) begin
        if (!slot_f) begin
          slot_f <= 1'b1;
          slot_i <= rd_idx;
        end
      end else if (e_s <= off) begin
        if (!prev_f || e_s > prev_s) begin
          prev_f <= 1'b1;
          prev_i <= rd_idx;
          prev_s <= e_s;
          prev_l <= e_l;
        end
      end else if (!next_f || e_s < next_s) begin
        next_f <= 1'b1;
        next_i <= rd_idx;
        next_s <= e_s;
        next_l <= e_l;
      end
    end
    if (cmd.quick_done) begin
      r_off    <= '0;
      r_status <= (kind == KIND_FREE) ? ST_OK : ST_NOFIT;
    end else if (cmd.post) begin
      r_off    <= (kind == KIND_ALLOC && alloc_ok) ? pick_s : '0;
      r_status <= post_status;
    end
    if (cmd.finish) begin
      res_offset <= r_off;
      res_status <= r_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

// File: design/variable_size_block_allocator_core.sv
// ----------------------------------------------------------------------------
// Variable-size block allocator
// Free-extent table allocator with first, best and worst fit and merge on free.
// ----------------------------------------------------------------------------
// Requests come in on the s_ stream: tuser is the kind (allocate or free),
// tdata carries offset and size. Each request gives one beat on the m_
// stream: tdata is the granted offset, tuser the status.
// The cfg port writes pool_size (index 0) or fit_policy (index 1).
// A request is processed one at a time: after accept it passes a check,
// a scan of the extent table through the single read port of its RAM, a
// write (and a second write when a free merges on both sides) and output.
// A request answered without a scan (zero size, or an allocate larger than
// the free total) goes from the check straight to output. The next request
// is taken once the result has been loaded.
// After reset, and after every pool_size write, a clearing pass over every
// table entry rebuilds the table; no request is taken during it.
// The result sits in an output register; while the receiver stalls the next
// request is still accepted and processed, and is held before output until
// that register is free.
// ----------------------------------------------------------------------------
module variable_size_block_allocator_core #(
  parameter int MAX_EXTENTS = vsba_pkg::MAX_EXTENTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // offset[15:0], size[31:16]
  input  logic        s_tuser,   // kind[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // granted_offset[15:0]
  output logic [1:0]  m_tuser    // status[1:0]
);
  import vsba_pkg::*;

  vsba_cmd_t cmd;
  vsba_sts_t sts;
  logic [$clog2(MAX_EXTENTS)-1:0] idx;

  vsba_ctrl #(.MAX_EXTENTS(MAX_EXTENTS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd),
    .idx      (idx)
  );

  vsba_dp #(.MAX_EXTENTS(MAX_EXTENTS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_kind    (s_tuser),
    .in_offset  (s_tdata[15:0]),
    .in_size    (s_tdata[31:16]),
    .cmd        (cmd),
    .idx        (idx),
    .sts        (sts),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .res_offset (m_tdata),
    .res_status (m_tuser)
  );

endmodule
